[sv/slew_pkg.sv]
package slew_pkg;

    localparam int unsigned DataW   = 32;
    localparam int unsigned ThreshW = 31;
    localparam int unsigned OpW     = 2;
    localparam int unsigned CfgIdxW = 4;

    typedef logic [OpW-1:0]     opcode_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    localparam opcode_t OP_INIT   = 2'd0;
    localparam opcode_t OP_SET    = 2'd1;
    localparam opcode_t OP_STEP   = 2'd2;
    localparam opcode_t OP_SYNC   = 2'd3;

    localparam cfg_idx_t CFG_SLEW_COEFF     = 4'd0;
    localparam cfg_idx_t CFG_SNAP_THRESHOLD = 4'd1;

    localparam logic signed [DataW-1:0] SLEW_COEFF_RESET     = 32'sd0;
    localparam logic        [ThreshW-1:0] SNAP_THRESHOLD_RESET = 31'h800;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [DataW-1:0]  value;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } in_beat_t;

endpackage

[sv/one_pole_slew_smoother.sv]
// One-pole slew smoother: keeps a Q1.31 target and output and, on each step beat,
// moves the output toward the target by a fraction set by slew_coeff (one 32x32
// multiply, saturating). Opcodes: init, set target, step, sync query; every input
// beat gives exactly one result beat with the updated output. One beat per cycle
// sustained while m_ready keeps up; an accepted beat passes the input register, then
// the update into the state and result registers, to give its result. Configuration
// writes are always ready and must only be issued while no beat is in flight.
module one_pole_slew_smoother (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  slew_pkg::cfg_idx_t                 cfg_index,
    input  logic [slew_pkg::DataW-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  slew_pkg::opcode_t                  s_opcode,
    input  logic signed [slew_pkg::DataW-1:0]  s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [slew_pkg::DataW-1:0]  m_out_value,
    output logic                               m_settled
);

    slew_pkg::item_t    s_item;
    slew_pkg::in_beat_t beat;
    logic               core_ready;

    assign s_item.opcode = s_opcode;
    assign s_item.value  = s_value;

    slew_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .core_ready (core_ready),
        .beat       (beat)
    );

    slew_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .beat        (beat),
        .core_ready  (core_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_settled   (m_settled)
    );

endmodule

[sv/slew_in_stage.sv]
module slew_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  slew_pkg::item_t    s_item,
    input  logic               core_ready,
    output slew_pkg::in_beat_t beat
);

    logic            in_valid_reg;
    logic            in_valid_next;
    slew_pkg::item_t in_item_reg;

    assign s_ready = !in_valid_reg || core_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    assign beat.valid = in_valid_reg;
    assign beat.item  = in_item_reg;

endmodule

[sv/slew_core.sv]
module slew_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  slew_pkg::cfg_idx_t                   cfg_index,
    input  logic [slew_pkg::DataW-1:0]           cfg_data,
    input  slew_pkg::in_beat_t                   beat,
    output logic                                 core_ready,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [slew_pkg::DataW-1:0]    m_out_value,
    output logic                                 m_settled
);

    localparam int unsigned W = slew_pkg::DataW;
    localparam logic signed [W-1:0] QMax = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] QMin = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_wide(input logic signed [W:0] x);
        logic signed [W-1:0] r;
        if (x[W] != x[W-1]) begin
            r = x[W] ? QMin : QMax;
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0]                slew_coeff_reg;
    logic [slew_pkg::ThreshW-1:0]       snap_threshold_reg;
    logic signed [W-1:0]                target_reg;
    logic signed [W-1:0]                target_next;
    logic signed [W-1:0]                output_reg;
    logic signed [W-1:0]                output_next;
    logic                               res_valid_reg;
    logic                               res_valid_next;
    logic signed [W-1:0]                res_value_reg;
    logic                               res_settled_reg;
    logic                               settled_next;
    logic                               adv;

    logic signed [W:0]                  diff_wide;
    logic signed [W-1:0]                diff_sat;
    logic signed [2*W-1:0]              prod;
    logic signed [W-1:0]                frac_sat;
    logic signed [W:0]                  sum_wide;
    logic signed [W-1:0]                step_value;
    logic signed [W:0]                  rev_wide;
    logic signed [W-1:0]                rev_sat;
    logic signed [W:0]                  neg_wide;
    logic signed [W-1:0]                abs_gap;
    logic                               is_equal;
    logic                               in_snap;

    assign cfg_ready  = 1'b1;
    assign core_ready = !res_valid_reg || m_ready;
    assign adv        = beat.valid && core_ready;

    // step: target + frmul(coeff, sat(output - target))
    assign diff_wide  = {output_reg[W-1], output_reg} - {target_reg[W-1], target_reg};
    assign diff_sat   = sat_wide(diff_wide);
    assign prod       = slew_coeff_reg * diff_sat;
    assign frac_sat   = sat_wide(prod[2*W-1:W-1]);
    assign sum_wide   = {target_reg[W-1], target_reg} + {frac_sat[W-1], frac_sat};
    assign step_value = sat_wide(sum_wide);

    // sync: saturated distance to target
    assign rev_wide = {target_reg[W-1], target_reg} - {output_reg[W-1], output_reg};
    assign rev_sat  = sat_wide(rev_wide);
    assign neg_wide = -{rev_sat[W-1], rev_sat};
    assign abs_gap  = rev_sat[W-1] ? sat_wide(neg_wide) : rev_sat;
    assign is_equal = (output_reg == target_reg);
    assign in_snap  = (abs_gap[W-2:0] < snap_threshold_reg);

    always_comb begin
        target_next  = target_reg;
        output_next  = output_reg;
        settled_next = 1'b0;
        unique case (beat.item.opcode)
            slew_pkg::OP_INIT: begin
                target_next = beat.item.value;
                output_next = beat.item.value;
            end
            slew_pkg::OP_SET: begin
                target_next = beat.item.value;
            end
            slew_pkg::OP_STEP: begin
                output_next = step_value;
            end
            slew_pkg::OP_SYNC: begin
                if (is_equal) begin
                    settled_next = 1'b1;
                end else if (in_snap) begin
                    output_next = target_reg;
                end
            end
            default: begin
                output_next = output_reg;
            end
        endcase
    end

    always_comb begin
        res_valid_next = res_valid_reg;
        if (core_ready) begin
            res_valid_next = beat.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slew_coeff_reg     <= slew_pkg::SLEW_COEFF_RESET;
            snap_threshold_reg <= slew_pkg::SNAP_THRESHOLD_RESET;
            target_reg         <= '0;
            output_reg         <= '0;
            res_valid_reg      <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (adv) begin
                target_reg <= target_next;
                output_reg <= output_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == slew_pkg::CFG_SLEW_COEFF) begin
                    slew_coeff_reg <= cfg_data;
                end else if (cfg_index == slew_pkg::CFG_SNAP_THRESHOLD) begin
                    snap_threshold_reg <= cfg_data[slew_pkg::ThreshW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_value_reg   <= output_next;
            res_settled_reg <= settled_next;
        end
    end

    assign m_valid     = res_valid_reg;
    assign m_out_value = res_value_reg;
    assign m_settled   = res_settled_reg;

    a_init_aligns: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && beat.item.opcode == slew_pkg::OP_INIT) |=> (output_reg == target_reg))
        else $error("init beat left output and target apart");

    a_set_keeps_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && beat.item.opcode == slew_pkg::OP_SET) |=> $stable(output_reg))
        else $error("set target changed the output");

    a_sync_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && beat.item.opcode == slew_pkg::OP_SYNC && is_equal) |=> res_settled_reg)
        else $error("equal sync beat not reported settled");

    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (res_value_reg == output_reg))
        else $error("result beat differs from updated output");

endmodule
